FILE: src/dedup_slot_allocator_macros.svh
// Assertion macros for the slot allocator checker.
`ifndef DEDUP_SLOT_ALLOCATOR_MACROS_SVH
`define DEDUP_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, ignored while in reset
`define DSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset
`define DSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define DSA_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dsa_pkg.sv
`timescale 1ns / 1ps

package dsa_pkg;

  // Fixed field widths of the item ports
  localparam int KEY_W    = 64;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 3;

  // Default table geometry
  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int KEY_BITS_DEF    = 64;

  // Request kinds
  localparam logic KIND_CREATE  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_NEW      = 3'd0,
    ST_MATCH    = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

endpackage

FILE: src/dedup_slot_allocator.sv
`timescale 1ns / 1ps
// Deduplicating slot allocator.
// Input channel (in_valid / in_stall): in_kind selects create (key in in_key) or
// release (slot in in_slot_index). One result item per request leaves on the
// output channel (out_valid / out_stall) as out_slot and out_status.
// Create returns the live slot holding an equal key, else the lowest free slot
// at or above the search hint (which is then marked used), else reports full.
// Release frees a used slot and lowers the hint; a free or out-of-range slot is
// reported as ignored.
// A create walks every slot through the single read port of the slot memory,
// one entry per cycle, then goes to S_FINISH; a release passes S_REL_RD,
// S_REL_WB and S_FINISH, and a slot outside the table goes straight to S_FINISH.
// One request is in flight at a time: the next is taken the cycle after the
// result is loaded into the output register.
// Reset: after rst_n the block sweeps every entry of the slot memory, one entry
// per cycle, with in_stall high, then starts taking requests.
// A stalled result stays in the output register; the next request is still
// taken and worked on, and waits for the register to free before it is shown.
module dedup_slot_allocator
  import dsa_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [SLOT_W-1:0]   in_slot_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [STATUS_W-1:0] out_status
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int ENT_W = KEY_BITS + 1;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_REL_RD = 6'b001000,
    S_REL_WB = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  // Control
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  addr_r, addr_nxt;
  logic [CNT_W-1:0]  hint_r, hint_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                match_found_r, match_found_nxt;
  logic [IDX_W-1:0]    match_idx_r, match_idx_nxt;
  logic                free_found_r, free_found_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  status_t             out_status_r, out_status_nxt;

  // Slot memory: {used, key} per entry
  logic [ENT_W-1:0] slot_mem [TABLE_SLOTS];
  logic [ENT_W-1:0] rd_q_r;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [ENT_W-1:0] wr_data;

  logic issuing;
  logic in_range;
  logic ent_used;
  logic key_hit;

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_slot   = out_slot_r;
  assign out_status = out_status_r;

  assign issuing  = (state_r == S_SCAN) && (addr_r != CNT_W'(TABLE_SLOTS));
  assign in_range = (32'(in_slot_index) < 32'(TABLE_SLOTS));
  assign ent_used = rd_q_r[KEY_BITS];
  assign key_hit  = (rd_q_r[KEY_BITS-1:0] == key_r);

  // Next-state logic
  always_comb begin
    state_nxt       = state_r;
    addr_nxt        = addr_r;
    hint_nxt        = hint_r;
    rd_vld_nxt      = issuing;
    rd_idx_nxt      = addr_r[IDX_W-1:0];
    key_nxt         = key_r;
    match_found_nxt = match_found_r;
    match_idx_nxt   = match_idx_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    res_slot_nxt    = res_slot_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r;
    out_slot_nxt    = out_slot_r;
    out_status_nxt  = out_status_r;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_idx          = addr_r[IDX_W-1:0];
    wr_data         = '0;

    // result taken by the receiver
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (addr_r == CNT_W'(TABLE_SLOTS - 1)) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + CNT_W'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_CREATE) begin
            key_nxt         = in_key[KEY_BITS-1:0];
            addr_nxt        = '0;
            match_found_nxt = 1'b0;
            free_found_nxt  = 1'b0;
            state_nxt       = S_SCAN;
          end else begin
            res_slot_nxt = in_slot_index;
            if (in_range) begin
              addr_nxt  = CNT_W'(in_slot_index);
              state_nxt = S_REL_RD;
            end else begin
              res_status_nxt = ST_IGNORED;
              state_nxt      = S_FINISH;
            end
          end
        end
      end

      S_SCAN: begin
        // issue one read per cycle
        if (issuing) begin
          rd_en    = 1'b1;
          addr_nxt = addr_r + CNT_W'(1);
        end
        // examine the entry read last cycle
        if (rd_vld_r) begin
          if (ent_used && key_hit && !match_found_r) begin
            match_found_nxt = 1'b1;
            match_idx_nxt   = rd_idx_r;
          end
          if (!ent_used && !free_found_r && (CNT_W'(rd_idx_r) >= hint_r)) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = rd_idx_r;
          end
        end
        // walk finished: decide
        if (!issuing && !rd_vld_r) begin
          state_nxt = S_FINISH;
          if (match_found_r) begin
            res_slot_nxt   = SLOT_W'(match_idx_r);
            res_status_nxt = ST_MATCH;
          end else if (free_found_r) begin
            wr_en          = 1'b1;
            wr_idx         = free_idx_r;
            wr_data        = {1'b1, key_r};
            hint_nxt       = CNT_W'(free_idx_r) + CNT_W'(1);
            res_slot_nxt   = SLOT_W'(free_idx_r);
            res_status_nxt = ST_NEW;
          end else begin
            res_slot_nxt   = '0;
            res_status_nxt = ST_FULL;
          end
        end
      end

      S_REL_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_REL_WB;
      end

      S_REL_WB: begin
        state_nxt = S_FINISH;
        if (ent_used) begin
          wr_en          = 1'b1;
          res_status_nxt = ST_RELEASED;
          if (addr_r < hint_r) begin
            hint_nxt = addr_r;
          end
        end else begin
          res_status_nxt = ST_IGNORED;
        end
      end

      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = res_slot_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      hint_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      hint_r      <= hint_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    key_r         <= key_nxt;
    match_found_r <= match_found_nxt;
    match_idx_r   <= match_idx_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    res_slot_r    <= res_slot_nxt;
    res_status_r  <= res_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_status_r  <= out_status_nxt;
  end

  // Slot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= slot_mem[addr_r[IDX_W-1:0]];
    end
  end

endmodule

FILE: src/dsa_checker.sv
`timescale 1ns / 1ps
`include "dedup_slot_allocator_macros.svh"

module dsa_checker
  import dsa_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [SLOT_W-1:0]   out_slot,
  input logic [STATUS_W-1:0] out_status
);

  // memory sweep after reset holds off requests
  `DSA_ASSERT_NEXT_ALWAYS(a_reset_stalls, !rst_n, in_stall, "input not stalled after reset")

  // one request at a time: an accepted item closes the input
  `DSA_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second item taken early")

  // a full table reports slot zero
  `DSA_ASSERT_NOW(a_full_slot, out_valid && (out_status == ST_FULL), out_slot == '0,
                  "full result with nonzero slot")

  // stalled result holds
  `DSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_slot) && $stable(out_status),
                   "stalled result changed")

endmodule

bind dedup_slot_allocator dsa_checker u_dsa_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dsa_pkg::*;

  // Full-size table as the block is used; live slots gather at the low end,
  // so most releases aim there
  localparam int SLOTS = TABLE_SLOTS_DEF;
  localparam int KBITS = KEY_BITS_DEF;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KBITS);
  localparam int RANDOM_ITEMS = 555;
  localparam int POOL_KEYS = 24;
  localparam int LIVE_SPAN = 128;
  localparam int STUCK_LIMIT = 8 * SLOTS;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_kind = KIND_CREATE;
  logic [KEY_W-1:0]    in_key = '0;
  logic [SLOT_W-1:0]   in_slot_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SLOT_W-1:0]   out_slot;
  logic [STATUS_W-1:0] out_status;

  // Items waiting to be driven, and replies owed by the block
  req_t   requests[$];
  reply_t slot_replies[$];

  // Shadow of the slot table
  bit               live[SLOTS];
  logic [KEY_W-1:0] held_key[SLOTS];
  int unsigned      hint = 0;

  logic [KEY_W-1:0] key_pool[POOL_KEYS];

  int total_items = 0;
  int n_taken = 0;
  int mismatches = 0;
  int stuck_cycles = 0;
  bit in_took = 1'b0;
  bit out_took = 1'b0;

  dedup_slot_allocator #(
    .TABLE_SLOTS(SLOTS),
    .KEY_BITS   (KBITS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_key       (in_key),
    .in_slot_index(in_slot_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_slot     (out_slot),
    .out_status   (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one accepted item to the shadow table and returns its reply
  function automatic reply_t track_request(req_t r);
    reply_t           rp;
    logic [KEY_W-1:0] k;
    bit               done;
    rp.slot = '0;
    rp.status = ST_FULL;
    k = r.key & KEY_MASK;
    done = 1'b0;
    if (r.kind == KIND_CREATE) begin
      // live match first, lowest slot wins
      for (int i = 0; i < SLOTS && !done; i++) begin
        if (live[i] && held_key[i] == k) begin
          rp.slot = SLOT_W'(i);
          rp.status = ST_MATCH;
          done = 1'b1;
        end
      end
      // then the first free slot from the hint upwards; no wrap
      for (int i = int'(hint); i < SLOTS && !done; i++) begin
        if (!live[i]) begin
          live[i] = 1'b1;
          held_key[i] = k;
          hint = i + 1;
          rp.slot = SLOT_W'(i);
          rp.status = ST_NEW;
          done = 1'b1;
        end
      end
    end else begin
      rp.slot = r.index;
      if (r.index >= SLOTS || !live[r.index]) begin
        rp.status = ST_IGNORED;
      end else begin
        live[r.index] = 1'b0;
        if (r.index < hint) hint = r.index;
        rp.status = ST_RELEASED;
      end
    end
    return rp;
  endfunction

  task automatic queue_create(input logic [KEY_W-1:0] k);
    req_t r;
    r.kind = KIND_CREATE;
    r.key = k;
    r.index = SLOT_W'($urandom_range(1023));
    requests.push_back(r);
  endtask

  task automatic queue_release(input logic [SLOT_W-1:0] s);
    req_t r;
    r.kind = KIND_RELEASE;
    r.key = {$urandom, $urandom};
    r.index = s;
    requests.push_back(r);
  endtask

  // Driver: a new item, or a gap, once the current one has gone
  always @(negedge clk) begin
    int   gap_pct;
    int   hold_pct;
    req_t nxt;
    if (n_taken < total_items / 3) begin
      gap_pct = 8;
      hold_pct = 81;
    end else if (n_taken < 2 * total_items / 3) begin
      gap_pct = 81;
      hold_pct = 8;
    end else begin
      gap_pct = 0;
      hold_pct = 0;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = requests.pop_front();
          in_valid <= 1'b1;
          in_kind <= nxt.kind;
          in_key <= nxt.key;
          in_slot_index <= nxt.index;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < hold_pct);
    end
  end

  // Monitor: predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    reply_t want;
    req_t   r;
    bit     have_want;
    in_took = rst_n && in_valid && in_stall === 1'b0;
    out_took = rst_n && out_valid === 1'b1 && !out_stall;

    if (out_took) begin
      have_want = slot_replies.size() != 0;
      if (have_want) want = slot_replies.pop_front();
      if (!have_want || out_slot !== want.slot || out_status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          if (!have_want)
            $display("%0t: result slot=%0d status=%0d with none outstanding",
                     $time, out_slot, out_status);
          else
            $display("%0t: slot exp %0d got %0d, status exp %0d got %0d",
                     $time, want.slot, out_slot, want.status, out_status);
        end
      end
    end

    if (in_took) begin
      r.kind = in_kind;
      r.key = in_key;
      r.index = in_slot_index;
      slot_replies.push_back(track_request(r));
      n_taken++;
    end

    // watchdog on cycles with no handshake on either side
    if (!rst_n || in_took || out_took) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int create_pct;
    int burst;
    // directed: key extremes, match, single-bit key difference, re-use of a
    // released slot, releases of free slots at the top of the table
    queue_create('0);
    queue_create({KEY_W{1'b1}});
    queue_create('0);
    queue_create(64'd1);
    queue_release(SLOT_W'(1));
    queue_release(SLOT_W'(1));
    queue_create({KEY_W{1'b1}});
    queue_release(SLOT_W'(SLOTS - 2));
    queue_release(10'h3FF);
    queue_release(SLOT_W'(0));
    // a run of fresh keys, then a match and the top slot released while free
    for (int j = 0; j < 20; j++) queue_create(64'hA5A5_5A5A_0000_0000 | j);
    queue_create(64'd1);
    queue_release(SLOT_W'(SLOTS - 1));
    queue_create(64'h8000_0000_0000_0000);

    // random: bursts that lean to creates or to releases, keys mostly from a
    // small pool so that matches and refills of released slots occur
    for (int p = 0; p < POOL_KEYS; p++) key_pool[p] = {$urandom, $urandom};
    while (requests.size() < RANDOM_ITEMS + 25) begin
      create_pct = $urandom_range(1) ? 80 : 35;
      burst = $urandom_range(30, 8);
      for (int b = 0; b < burst; b++) begin
        if ($urandom_range(99) < 10)
          key_pool[$urandom_range(POOL_KEYS - 1)] =
            key_pool[$urandom_range(POOL_KEYS - 1)] ^ (64'd1 << $urandom_range(63));
        if ($urandom_range(99) < create_pct) begin
          if ($urandom_range(99) < 85) queue_create(key_pool[$urandom_range(POOL_KEYS - 1)]);
          else queue_create({$urandom, $urandom});
        end else begin
          if ($urandom_range(99) < 88) queue_release(SLOT_W'($urandom_range(LIVE_SPAN - 1)));
          else queue_release(SLOT_W'($urandom_range(1023)));
        end
      end
    end
    total_items = requests.size();

    // reset, then let everything drain
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (n_taken < total_items || slot_replies.size() != 0) @(negedge clk);
    repeat (SLOTS + 8) @(negedge clk);

    if (mismatches == 0 && slot_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
